### src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and defaults for the ring buffer deque.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // operation codes carried on s_tuser; unused codes act as a query
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### src/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue held in a circular synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload (lowest bit first)
//  --------  ---  -----------------  -----------------------------------------
//  s_        in   s_tvalid/s_tready  tuser: op code; tdata: value
//  m_        out  m_tvalid/m_tready  tdata: front, back, fill level, empty,
//                                    full, rejected, zero pad
//
//  Each transaction runs through the FSM states in order: the operation and
//  its memory write in the accept cycle, a read of the new front and back
//  entries from the two memory read ports, then the result is loaded into
//  the output register. The single write port and registered reads set this.
//  Reset (aresetn low, synchronous) clears the pointers, fill count and FSM;
//  the entry memory is not cleared, as only occupied entries are ever read.
//  A stalled result holds the FSM in its response state; the input is not
//  taken again until the result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW   = 2 * DATA_WIDTH + CNT_W + 3,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // value, zero pad
    input  wire logic [2:0]       s_tuser,   // op code

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // front, back, fill, empty, full,
                                             // rejected, zero pad
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    // entry store: one write port, two registered read ports
    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic                  rej_reg, rej_next;
    logic [DATA_WIDTH-1:0] rd_front_reg, rd_back_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                  accept;
    logic                  out_free;
    logic                  q_full, q_empty;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] in_value;
    logic [IDX_W-1:0]      tail_last;
    logic [DATA_WIDTH-1:0] res_front, res_back;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_full    = (fill_reg == CAP_CNT);
    assign q_empty   = (fill_reg == '0);
    assign in_value  = s_tdata[DATA_WIDTH-1:0];
    assign tail_last = idx_dec(tail_reg);
    assign res_front = q_empty ? '0 : rd_front_reg;
    assign res_back  = q_empty ? '0 : rd_back_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            rej_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            rej_reg      <= rej_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // write in the accept cycle, read back in the following cycle: no overlap
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            rd_front_reg <= mem[head_reg];
            rd_back_reg  <= mem[tail_last];
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        rej_next      = rej_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rej_next   = 1'b0;
                    state_next = ST_READ;
                    case (op_t'(s_tuser))
                        OP_PUSH_FRONT: begin
                            if (q_full) begin
                                rej_next = 1'b1;
                            end else begin
                                head_next = idx_dec(head_reg);
                                wr_en     = 1'b1;
                                wr_addr   = idx_dec(head_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (q_full) begin
                                rej_next = 1'b1;
                            end else begin
                                tail_next = idx_inc(tail_reg);
                                wr_en     = 1'b1;
                                wr_addr   = tail_reg;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (q_empty) begin
                                rej_next = 1'b1;
                            end else begin
                                head_next = idx_inc(head_reg);
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (q_empty) begin
                                rej_next = 1'b1;
                            end else begin
                                tail_next = idx_dec(tail_reg);
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        default: begin
                            // query and unused codes: no change
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({rej_reg, q_full, q_empty,
                                            fill_reg, res_back, res_front});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    logic [IDX_W:0] ptr_gap;

    assign ptr_gap = (tail_reg >= head_reg)
                   ? ({1'b0, tail_reg} - {1'b0, head_reg})
                   : ({1'b0, tail_reg} + (IDX_W + 1)'(CAPACITY) - {1'b0, head_reg});

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_CNT)
        else $error("fill count beyond capacity");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full ? (head_reg == tail_reg) : (CNT_W'(ptr_gap) == fill_reg))
        else $error("head/tail distance disagrees with fill count");

    a_accept_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_READ) && !s_tready)
        else $error("accepted transaction did not start a read");

    a_resp_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) && out_free |=> m_tvalid_reg && s_tready)
        else $error("result not loaded into output register");

endmodule

`default_nettype wire
